// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and codes for the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam int CNT_OUT_W = 5;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic               op;
    logic signed [31:0] value;
    logic signed [15:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]    popped_value;
    status_t               status;
    logic [CNT_OUT_W-1:0]  count;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t ent;
  } spq_cmd_t;

endpackage

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: keeps, takes the new entry or shifts
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic              clk,
  input  spq_pkg::spq_cmd_t cmd,
  input  logic              occupied,
  input  logic              prev_take,
  input  spq_pkg::entry_t   prev_ent,
  input  spq_pkg::entry_t   next_ent,
  output logic              take_o,
  output spq_pkg::entry_t   ent_o
);
  import spq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // free slot or stored priority strictly below the new one
  assign take_o = !occupied || ($signed(ent_r.prio) < $signed(cmd.ent.prio));
  assign ent_o  = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.push) begin
      if (prev_take) begin
        ent_nxt = prev_ent;
      end else if (take_o) begin
        ent_nxt = cmd.ent;
      end
    end else if (cmd.pop) begin
      ent_nxt = next_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ===== rtl/sorted_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// bounded priority queue kept sorted in a chain of cells
// ----------------------------------------------------------------------------
// usage:
//   in_data carries op (push or pop), value and priority_req; a transfer
//   happens when in_valid and in_ready are both high.
//   every input transfer gives exactly one result on out_data: the popped
//   value (0 unless a pop succeeded), a status and the count afterwards.
//   out_valid rises in the cycle after an input transfer. one item per
//   cycle is sustained while out_ready stays high, as the whole cell row
//   updates at once: every cell compares its priority with the new one
//   in parallel and shifts toward its neighbor in the same cycle.
//   equal priorities leave in arrival order. a push to a full queue is
//   dropped with status full, a pop on an empty queue gives status empty.
//   reset (rst_n low, synchronous) empties the queue and drops any pending
//   result. while out_ready is low a waiting result holds and in_ready
//   drops; the input side resumes in the cycle the result is taken.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output spq_pkg::out_item_t out_data
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  out_item_t     out_data_r;
  out_item_t     out_data_nxt;

  logic     accept;
  logic     is_full;
  logic     is_empty;
  spq_cmd_t cmd;

  logic   take   [DEPTH];
  entry_t ent    [DEPTH];

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign is_full   = (count_r == FULL_CNT);
  assign is_empty  = (count_r == '0);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cmd.push      = accept && (in_data.op == OP_PUSH) && !is_full;
  assign cmd.pop       = accept && (in_data.op == OP_POP) && !is_empty;
  assign cmd.ent.value = in_data.value;
  assign cmd.ent.prio  = in_data.priority_req;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic   occ;
    logic   p_take;
    entry_t p_ent;
    entry_t n_ent;

    assign occ = (IDX < count_r);

    if (i == 0) begin : g_first
      assign p_take = 1'b0;
      assign p_ent  = ent[0];
    end else begin : g_mid
      assign p_take = take[i-1];
      assign p_ent  = ent[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign n_ent = ent[i];
    end else begin : g_next
      assign n_ent = ent[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occupied  (occ),
      .prev_take (p_take),
      .prev_ent  (p_ent),
      .next_ent  (n_ent),
      .take_o    (take[i]),
      .ent_o     (ent[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CW'(1);
    end

    out_data_nxt.popped_value = cmd.pop ? ent[0].value : 32'sd0;
    out_data_nxt.count        = CNT_OUT_W'(count_nxt);
    if (in_data.op == OP_POP) begin
      out_data_nxt.status = is_empty ? ST_EMPTY : ST_OK;
    end else begin
      out_data_nxt.status = is_full ? ST_FULL : ST_OK;
    end

    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ===== rtl/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// port-level checks for the sorted priority queue
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int DEPTH = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input spq_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input spq_pkg::out_item_t out_data
);
  import spq_pkg::*;

  // waiting input holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed while waiting");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // every input transfer shows a result next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("input transfer without result");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |->
      out_data.count == CNT_OUT_W'(DEPTH) && out_data.popped_value == 32'sd0)
    else $error("full status with wrong count");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |->
      out_data.count == '0 && out_data.popped_value == 32'sd0)
    else $error("empty status with wrong count");

endmodule

bind sorted_priority_queue_unit spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
